FILE: rtl/btbsal_pkg.sv
// Shared types and constants for the set-associative BTB lookup block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package btbsal_pkg;

    // Byte-offset bits dropped from the branch PC
    localparam int PC_LOW_BITS = 2;

    // Rank given to the most recently used way
    localparam int RANK_MRU = 1;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // take a request: latch set/tag, issue set read
        logic clear_step;  // write one zeroed row of the clearing pass
        logic commit;      // write back updated set, load result register
    } btbsal_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last row
        logic out_stall;   // result register full and not being taken
    } btbsal_stat_t;

endpackage

`default_nettype wire

FILE: rtl/btb_set_assoc_lru_lookup.sv
// Top level of the set-associative branch target buffer lookup with true-LRU ranks.
// Depends on btbsal_pkg, btbsal_ctrl, btbsal_dp (and btbsal_ram through it).
//
// Each request carries one branch PC; the block answers with a hit flag and the
// way that hit, was filled, or was replaced, updating the set's LRU ranks. A
// request first reads its set row from the set RAM (registered read), then does
// tag compare, rank update and writeback of the row; no new request is taken
// until the previous one has been written back. The lookup cycle
// waits when the previous result is still held at the output. After reset a
// clearing pass writes every set row to zero, one row a cycle, during which no
// request is taken.
`default_nettype none

module btb_set_assoc_lru_lookup
    import btbsal_pkg::*;
#(
    parameter int SET_INDEX_BITS = 6,
    parameter int WAYS           = 4,
    parameter int PC_BITS        = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_branch_pc,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [1:0]       m_way_used
);

    btbsal_cmd_t  cmd;
    btbsal_stat_t stat;

    btbsal_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    btbsal_dp #(
        .SET_INDEX_BITS(SET_INDEX_BITS),
        .WAYS          (WAYS),
        .PC_BITS       (PC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_branch_pc(s_branch_pc),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_way_used (m_way_used)
    );

endmodule

`default_nettype wire

FILE: rtl/btbsal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module btbsal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/btbsal_ctrl.sv
// Controller state machine for the BTB lookup: clearing pass, idle, lookup.
// Depends on btbsal_pkg for the command and status structs.
`default_nettype none

module btbsal_ctrl
    import btbsal_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire btbsal_stat_t stat,
    output btbsal_cmd_t       cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.capture    = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // wait here while the previous result is still held
                if (!stat.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/btbsal_dp.sv
// Datapath for the BTB lookup: set RAM, tag compare, LRU rank update, result register.
// Depends on btbsal_pkg and btbsal_ram.
`default_nettype none

module btbsal_dp
    import btbsal_pkg::*;
#(
    parameter int SET_INDEX_BITS = 6,
    parameter int WAYS           = 4,
    parameter int PC_BITS        = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire btbsal_cmd_t cmd,
    output btbsal_stat_t     stat,
    input  wire logic [31:0] s_branch_pc,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [1:0]       m_way_used
);

    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int TAG_W    = PC_BITS - PC_LOW_BITS - SET_INDEX_BITS;
    localparam int RANK_W   = $clog2(WAYS + 1);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W  = 1 + TAG_W + RANK_W;
    localparam int ROW_W    = WAYS * ENTRY_W;

    localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(WAYS);
    localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(RANK_MRU);

    // PC at PC_BITS width: truncate or zero-extend the 32-bit port
    logic [PC_BITS-1:0] pc_ext;
    generate
        if (PC_BITS >= 32) begin : g_pc_wide
            assign pc_ext = PC_BITS'(s_branch_pc);
        end else begin : g_pc_narrow
            assign pc_ext = s_branch_pc[PC_BITS-1:0];
        end
    endgenerate

    logic [SET_INDEX_BITS-1:0] in_set;
    logic [TAG_W-1:0]          in_tag;
    assign in_set = pc_ext[PC_LOW_BITS +: SET_INDEX_BITS];
    assign in_tag = pc_ext[PC_BITS-1 -: TAG_W];

    // request latch
    logic [SET_INDEX_BITS-1:0] set_reg;
    logic [TAG_W-1:0]          tag_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
    end

    // clearing pass row counter
    logic [SET_INDEX_BITS-1:0] clr_addr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + SET_INDEX_BITS'(1);
        end
    end

    // set RAM: one row holds all ways of a set
    logic                      ram_we;
    logic [SET_INDEX_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;
    logic [ROW_W-1:0]          row_new;

    assign ram_we    = cmd.clear_step | cmd.commit;
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : set_reg;
    assign ram_wdata = cmd.clear_step ? '0 : row_new;

    btbsal_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_SETS)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.capture),
        .raddr(in_set),
        .rdata(ram_rdata)
    );

    // unpack the set row
    logic              way_v   [WAYS];
    logic [TAG_W-1:0]  way_t   [WAYS];
    logic [RANK_W-1:0] way_r   [WAYS];
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            way_v[w] = ram_rdata[w*ENTRY_W + TAG_W + RANK_W];
            way_t[w] = ram_rdata[w*ENTRY_W + RANK_W +: TAG_W];
            way_r[w] = ram_rdata[w*ENTRY_W +: RANK_W];
        end
    end

    // saturating age
    function automatic logic [RANK_W-1:0] age(input logic [RANK_W-1:0] r);
        return (r < RANK_LRU) ? r + RANK_W'(1) : r;
    endfunction

    // tag match, first free way, least-recent way
    logic              found;
    logic [WAY_W-1:0]  hit_w;
    logic              have_free;
    logic [WAY_W-1:0]  free_w;
    logic              have_lru;
    logic [WAY_W-1:0]  lru_w;
    always_comb begin
        found     = 1'b0;
        hit_w     = '0;
        have_free = 1'b0;
        free_w    = '0;
        have_lru  = 1'b0;
        lru_w     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (way_v[w]) begin
                if (!found && way_t[w] == tag_reg) begin
                    found = 1'b1;
                    hit_w = WAY_W'(w);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_w    = WAY_W'(w);
            end
            if (!have_lru && way_r[w] == RANK_LRU) begin
                have_lru = 1'b1;
                lru_w    = WAY_W'(w);
            end
        end
    end

    // way chosen and its old rank
    logic [WAY_W-1:0]  used_w;
    logic [RANK_W-1:0] hit_rank;
    always_comb begin
        priority if (found) begin
            used_w = hit_w;
        end else if (have_free) begin
            used_w = free_w;
        end else begin
            // full set: rank-WAYS way, way 0 if none
            used_w = lru_w;
        end
        hit_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == hit_w) begin
                hit_rank = way_r[w];
            end
        end
    end

    // updated row
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            logic              v;
            logic [TAG_W-1:0]  t;
            logic [RANK_W-1:0] r;
            v = way_v[w];
            t = way_t[w];
            r = way_r[w];
            if (WAY_W'(w) == used_w) begin
                v = 1'b1;
                if (!found) begin
                    t = tag_reg;
                end
                r = RANK_ONE;
            end else if (found) begin
                if (way_v[w] && way_r[w] < hit_rank) begin
                    r = age(way_r[w]);
                end
            end else if (have_free) begin
                if (way_v[w]) begin
                    r = age(way_r[w]);
                end
            end else begin
                r = age(way_r[w]);
            end
            row_new[w*ENTRY_W +: ENTRY_W] = {v, t, r};
        end
    end

    // result register
    logic m_valid_reg;
    logic m_hit_reg;
    logic [1:0] m_way_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_hit_reg <= found;
            m_way_reg <= 2'(used_w);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_way_used = m_way_reg;

    assign stat.clear_last = &clr_addr_reg;
    assign stat.out_stall  = m_valid_reg & ~m_ready;

endmodule

`default_nettype wire

FILE: tb/sv/btb_set_assoc_lru_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for btb_set_assoc_lru_lookup: directed and random branch PC requests.
// An in-bench copy of the valid bits, tags and LRU ranks predicts each result.
// Depends on btbsal_pkg and the block's RTL.
module btb_set_assoc_lru_lookup_tb
    import btbsal_pkg::*;
();

    localparam int SET_BITS   = 6;
    localparam int NUM_WAYS   = 4;
    localparam int ADDR_BITS  = 32;
    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int LINE_BITS  = ADDR_BITS - PC_LOW_BITS;
    localparam int TAG_BITS   = LINE_BITS - SET_BITS;
    localparam int N_RANDOM   = 450;
    localparam int TIMEOUT_NS = 400000;

    typedef struct packed {
        logic       hit;
        logic [1:0] way;
    } lookup_res_t;

    typedef struct packed {
        logic        drain;  // hold this request until all results are back
        logic [31:0] pc;
    } pend_req_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [31:0] s_branch_pc = '0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_hit;
    logic [1:0]  m_way_used;

    // Predicted BTB contents
    logic                set_valid [NUM_SETS*NUM_WAYS];
    logic [TAG_BITS-1:0] set_tag   [NUM_SETS*NUM_WAYS];
    logic [2:0]          set_rank  [NUM_SETS*NUM_WAYS];

    pend_req_t   pend_q[$];
    lookup_res_t lookup_q[$];

    int errors       = 0;
    int n_directed   = 0;
    int n_hit        = 0;
    int n_fill       = 0;
    int n_evict      = 0;
    int reqs_offered = 0;
    int reqs_taken   = 0;
    int res_taken    = 0;
    int res_seen     = 0;

    btb_set_assoc_lru_lookup #(
        .SET_INDEX_BITS(SET_BITS),
        .WAYS          (NUM_WAYS),
        .PC_BITS       (ADDR_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_branch_pc(s_branch_pc),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_way_used (m_way_used)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Saturating age of one entry
    function automatic void age_rank(input int e);
        if (set_rank[e] < NUM_WAYS)
            set_rank[e] = set_rank[e] + 3'd1;
    endfunction

    // Look up one PC, update the predicted set, return the expected result
    function automatic lookup_res_t btb_lookup(input logic [31:0] pc);
        logic [LINE_BITS-1:0] line;
        logic [TAG_BITS-1:0]  tag;
        logic [2:0]           hit_rank;
        int                   base, used, free_way, w;
        bit                   found, have_free;
        lookup_res_t          res;
        line      = pc[ADDR_BITS-1:PC_LOW_BITS];
        tag       = line[LINE_BITS-1:SET_BITS];
        base      = int'(line[SET_BITS-1:0]) * NUM_WAYS;
        found     = 1'b0;
        have_free = 1'b0;
        used      = 0;
        free_way  = 0;
        for (w = 0; w < NUM_WAYS; w++) begin
            if (set_valid[base+w]) begin
                if (!found && set_tag[base+w] == tag) begin
                    found = 1'b1;
                    used  = w;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_way  = w;
            end
        end
        if (found) begin
            // only ways more recent than the hit way age
            hit_rank = set_rank[base+used];
            for (w = 0; w < NUM_WAYS; w++)
                if (set_valid[base+w] && set_rank[base+w] < hit_rank)
                    age_rank(base + w);
            set_rank[base+used] = 3'(RANK_MRU);
            n_hit++;
        end else if (have_free) begin
            // cold fill of the lowest free way
            for (w = 0; w < NUM_WAYS; w++)
                if (set_valid[base+w])
                    age_rank(base + w);
            used                 = free_way;
            set_valid[base+used] = 1'b1;
            set_tag[base+used]   = tag;
            set_rank[base+used]  = 3'(RANK_MRU);
            n_fill++;
        end else begin
            // full set: evict the lowest way of rank WAYS, way 0 if none
            used = 0;
            for (w = NUM_WAYS - 1; w >= 0; w--)
                if (set_rank[base+w] == NUM_WAYS)
                    used = w;
            for (w = 0; w < NUM_WAYS; w++)
                if (w != used)
                    age_rank(base + w);
            set_tag[base+used]  = tag;
            set_rank[base+used] = 3'(RANK_MRU);
            n_evict++;
        end
        res.hit = found;
        res.way = used[1:0];
        return res;
    endfunction

    function automatic logic [31:0] make_pc(input logic [TAG_BITS-1:0] tag, input int set,
                                            input logic [1:0] low);
        logic [SET_BITS-1:0] s;
        s = set[SET_BITS-1:0];
        return {tag, s, low};
    endfunction

    task automatic queue_req(input logic [31:0] pc, input logic drain);
        pend_req_t r;
        r.drain = drain;
        r.pc    = pc;
        pend_q.push_back(r);
    endtask

    // Request driver: one request at a time, random gap before each
    pend_req_t cur_req    = '0;
    bit        send_busy  = 1'b0;
    bit        send_burst = 1'b0;
    int        send_gap   = 0;

    always @(negedge aclk) begin : drv
        if (aresetn) begin
            if (send_busy && reqs_taken == reqs_offered) begin
                send_busy = 1'b0;
                send_gap  = send_burst ? 0 : $urandom_range(0, 6);
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 &&
                             (!pend_q[0].drain || lookup_q.size() == 0)) begin
                    cur_req   = pend_q.pop_front();
                    send_busy = 1'b1;
                    reqs_offered++;
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                end
            end
            s_valid     <= send_busy;
            s_branch_pc <= cur_req.pc;
        end
    end

    // Result side back-pressure: random stall after each result
    bit recv_burst = 1'b0;
    int recv_stall = 0;

    always @(negedge aclk) begin : rcv
        if (res_taken != res_seen) begin
            res_seen   = res_taken;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: check results, then record accepted requests
    always @(posedge aclk) begin : mon
        lookup_res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                res_taken++;
                if (lookup_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual hit=%0d way=%0d",
                             $time, m_hit, m_way_used);
                end else begin
                    want = lookup_q.pop_front();
                    if (m_hit !== want.hit) begin
                        errors++;
                        $display("%0t: hit mismatch: expected %0d, actual %0d",
                                 $time, want.hit, m_hit);
                    end
                    if (m_way_used !== want.way) begin
                        errors++;
                        $display("%0t: way_used mismatch: expected %0d, actual %0d",
                                 $time, want.way, m_way_used);
                    end
                end
            end
            if (s_valid && s_ready) begin
                lookup_q.push_back(btb_lookup(s_branch_pc));
                reqs_taken++;
            end
        end
    end

    initial begin : main
        logic [TAG_BITS-1:0] tag_pool [6];
        int                  hot_set  [4];
        int                  i, e;

        for (e = 0; e < NUM_SETS * NUM_WAYS; e++) begin
            set_valid[e] = 1'b0;
            set_tag[e]   = '0;
            set_rank[e]  = '0;
        end

        // Directed: field extremes, ignored low bits, fills, hits, evictions
        queue_req(32'h0000_0000, 1'b0);
        queue_req(32'h0000_0003, 1'b0);              // same line, low bits differ
        queue_req(32'hFFFF_FFFF, 1'b0);
        queue_req(32'hFFFF_FFFC, 1'b0);
        queue_req(32'hAAAA_AAAA, 1'b0);
        queue_req(32'h5555_5555, 1'b0);
        queue_req(make_pc(24'h000001, 5, 2'd0), 1'b0);  // fill set 5, ways 0..3
        queue_req(make_pc(24'h800000, 5, 2'd1), 1'b0);
        queue_req(make_pc(24'h7FFFFF, 5, 2'd2), 1'b0);
        queue_req(make_pc(24'h123456, 5, 2'd3), 1'b0);
        queue_req(make_pc(24'h800000, 5, 2'd0), 1'b0);  // hit on a middle rank
        queue_req(make_pc(24'h123456, 5, 2'd1), 1'b0);
        queue_req(make_pc(24'hABCDEF, 5, 2'd2), 1'b0);  // full set, evict LRU
        queue_req(make_pc(24'h000001, 5, 2'd3), 1'b0);
        queue_req(make_pc(24'hABCDEF, 5, 2'd0), 1'b0);
        queue_req(make_pc(24'hABCDEF, 5, 2'd1), 1'b0);  // hit on the MRU way
        queue_req(make_pc(24'h7FFFFF, 5, 2'd2), 1'b0);
        queue_req(make_pc(24'h000000, NUM_SETS - 1, 2'd0), 1'b0);
        queue_req(make_pc(24'hFFFFFF, 0, 2'd2), 1'b0);
        n_directed = pend_q.size();

        // Random: a few hot sets and a small tag pool force hits and evictions
        hot_set[0] = 0;
        hot_set[1] = NUM_SETS - 1;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 0 || i == N_RANDOM / 2) begin
                hot_set[2] = $urandom_range(0, NUM_SETS - 1);
                hot_set[3] = $urandom_range(0, NUM_SETS - 1);
                for (e = 2; e < 6; e++)
                    tag_pool[e] = TAG_BITS'($urandom);
            end
            if ($urandom_range(0, 99) < 15)
                queue_req($urandom, i == N_RANDOM / 2);
            else
                queue_req(make_pc(tag_pool[$urandom_range(0, 5)],
                                  hot_set[$urandom_range(0, 3)],
                                  2'($urandom_range(0, 3))),
                          i == 0 || i == N_RANDOM / 2);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || send_busy || lookup_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Ran %0d lookups (%0d directed) over hot and random sets:", reqs_taken,
                 n_directed);
        $display("  %0d hits, %0d cold fills, %0d LRU evictions, %0d mismatches",
                 n_hit, n_fill, n_evict, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: btb_set_assoc_lru_lookup.f
rtl/btbsal_pkg.sv
rtl/btbsal_ram.sv
rtl/btbsal_ctrl.sv
rtl/btbsal_dp.sv
rtl/btb_set_assoc_lru_lookup.sv
tb/sv/btb_set_assoc_lru_lookup_tb.sv
